// ===== sv/assert_macros.svh =====
// assertion helpers shared by the rtl
// expects clk and arst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SFPD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SFPD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/sfpd_pkg.sv =====
// types and constants of the framed packet deframer
// no dependencies
package sfpd_pkg;

	localparam int BYTE_W  = 8;
	localparam int TDATA_W = 40;

	localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'd129;
	localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'd161;

	localparam logic CFG_SYNC_FIRST  = 1'b0;
	localparam logic CFG_SYNC_SECOND = 1'b1;

	localparam logic ITEM_PAYLOAD   = 1'b0;
	localparam logic ITEM_FRAME_END = 1'b1;

	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_ID   = 3'd1,
		PH_LEN  = 3'd2,
		PH_DATA = 3'd3,
		PH_CK0  = 3'd4,
		PH_CK1  = 3'd5
	} phase_t;

	typedef struct packed {
		logic              item_kind;
		logic [BYTE_W-1:0] message_id;
		logic [BYTE_W-1:0] byte_index;
		logic [BYTE_W-1:0] payload_byte;
		logic [BYTE_W-1:0] frame_length;
		logic              checksum_good;
	} result_t;

endpackage

// ===== sv/sfpd_parser.sv =====
// frame parser: sync hunt, field sequencing and fletcher-style sums modulo 256
// depends on sfpd_pkg
module sfpd_parser (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  logic [7:0]              rx_byte,
	input  logic [7:0]              sync_first,
	input  logic [7:0]              sync_second,
	output logic                    emit,
	output sfpd_pkg::result_t       res
);
	import sfpd_pkg::*;

	phase_t            phase_q, phase_d;
	logic [BYTE_W-1:0] prior_q, prior_d;
	logic              prior_vld_q, prior_vld_d;
	logic [BYTE_W-1:0] id_q, id_d;
	logic [BYTE_W-1:0] size_q, size_d;
	logic [BYTE_W-1:0] seen_q, seen_d;
	logic [BYTE_W-1:0] c0_q, c0_d;
	logic [BYTE_W-1:0] c1_q, c1_d;
	logic [BYTE_W-1:0] ck0_q, ck0_d;
	logic [BYTE_W-1:0] seen_inc;
	logic [BYTE_W-1:0] c0_add;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			prior_q     <= '0;
			prior_vld_q <= 1'b0;
			id_q        <= '0;
			size_q      <= '0;
			seen_q      <= '0;
			c0_q        <= '0;
			c1_q        <= '0;
			ck0_q       <= '0;
		end else if (step) begin
			phase_q     <= phase_d;
			prior_q     <= prior_d;
			prior_vld_q <= prior_vld_d;
			id_q        <= id_d;
			size_q      <= size_d;
			seen_q      <= seen_d;
			c0_q        <= c0_d;
			c1_q        <= c1_d;
			ck0_q       <= ck0_d;
		end
	end

	assign seen_inc = seen_q + 8'd1;
	assign c0_add   = c0_q + rx_byte;

	always_comb begin
		phase_d     = phase_q;
		prior_d     = prior_q;
		prior_vld_d = prior_vld_q;
		id_d        = id_q;
		size_d      = size_q;
		seen_d      = seen_q;
		c0_d        = c0_q;
		c1_d        = c1_q;
		ck0_d       = ck0_q;
		emit        = 1'b0;
		res.item_kind     = ITEM_PAYLOAD;
		res.message_id    = id_q;
		res.byte_index    = '0;
		res.payload_byte  = '0;
		res.frame_length  = size_q;
		res.checksum_good = 1'b0;
		case (phase_q)
			PH_ID: begin
				id_d    = rx_byte;
				c0_d    = rx_byte;
				c1_d    = rx_byte;
				phase_d = PH_LEN;
			end
			PH_LEN: begin
				size_d  = rx_byte;
				c0_d    = c0_add;
				c1_d    = c1_q + c0_add;
				seen_d  = '0;
				phase_d = (rx_byte == '0) ? PH_CK0 : PH_DATA;
			end
			PH_DATA: begin
				emit             = 1'b1;
				res.byte_index   = seen_q;
				res.payload_byte = rx_byte;
				c0_d             = c0_add;
				c1_d             = c1_q + c0_add;
				seen_d           = seen_inc;
				if (seen_inc == size_q) begin
					phase_d = PH_CK0;
				end
			end
			PH_CK0: begin
				ck0_d   = rx_byte;
				phase_d = PH_CK1;
			end
			PH_CK1: begin
				emit              = 1'b1;
				res.item_kind     = ITEM_FRAME_END;
				res.checksum_good = (c0_q == ck0_q) && (c1_q == rx_byte);
				phase_d           = PH_HUNT;
				prior_vld_d       = 1'b0;
				prior_d           = '0;
			end
			default: begin
				if (prior_vld_q && prior_q == sync_first && rx_byte == sync_second) begin
					phase_d     = PH_ID;
					prior_vld_d = 1'b0;
					prior_d     = '0;
				end else begin
					phase_d     = PH_HUNT;
					prior_d     = rx_byte;
					prior_vld_d = 1'b1;
				end
			end
		endcase
	end

endmodule

// ===== sv/sfpd_out_reg.sv =====
// result register on the master side of the stream
// depends on sfpd_pkg
module sfpd_out_reg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  sfpd_pkg::result_t             res,
	output logic                          free,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [sfpd_pkg::TDATA_W-1:0]  m_tdata,
	output logic                          m_tuser
);
	import sfpd_pkg::*;

	logic    vld_q;
	result_t res_q;

	assign free = !vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (free) begin
			vld_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			res_q <= res;
		end
	end

	assign m_tvalid = vld_q;
	assign m_tuser  = res_q.item_kind;
	assign m_tdata  = {7'd0, res_q.checksum_good, res_q.frame_length,
		res_q.payload_byte, res_q.byte_index, res_q.message_id};

endmodule

// ===== sv/sync_framed_packet_deframer_core.sv =====
// top level of the framed packet deframer: input register, sync registers,
// parser and result register; depends on sfpd_pkg, sfpd_parser, sfpd_out_reg
//
// channel   dir  signals                    contents
// s_        in   tvalid tready tdata[7:0]   rx_byte
// m_        out  tvalid tready tdata tuser  see port comments
// cfg_      in   we index data              0 sync_first, 1 sync_second
//
// one item per cycle sustained unless m_tready stalls the result register; an item is held in the
// input register and then reaches the result register, which takes it once it is free
// reset clears the parser to hunting and loads sync 0x81 0xa1
// a stalled result register holds the input register, which then drops tready
`include "assert_macros.svh"
module sync_framed_packet_deframer_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // rx_byte
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// message_id, byte_index, payload_byte, frame_length, checksum_good, zero pad
	output logic [sfpd_pkg::TDATA_W-1:0]  m_tdata,
	output logic                          m_tuser,   // item_kind
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [7:0]                    cfg_data
);
	import sfpd_pkg::*;

	logic              vld_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic [BYTE_W-1:0] sync_first_q;
	logic [BYTE_W-1:0] sync_second_q;
	logic              out_free;
	logic              advance;
	logic              emit;
	result_t           res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= SYNC_FIRST_RST;
			sync_second_q <= SYNC_SECOND_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SYNC_FIRST:  sync_first_q  <= cfg_data;
				CFG_SYNC_SECOND: sync_second_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance  = vld_s1 && out_free;
	assign s_tready = !vld_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	sfpd_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.rx_byte     (byte_s1),
		.sync_first  (sync_first_q),
		.sync_second (sync_second_q),
		.emit        (emit),
		.res         (res)
	);

	sfpd_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && emit),
		.res      (res),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	`SFPD_ASSERT_NOW(a_end_fields_zero, m_tvalid && m_tuser == ITEM_FRAME_END, m_tdata[23:8] == 16'd0, "frame end item with index or data set")
	`SFPD_ASSERT_NOW(a_payload_no_good, m_tvalid && m_tuser == ITEM_PAYLOAD, !m_tdata[32], "payload item with checksum flag set")
	`SFPD_ASSERT_NOW(a_stall_blocks_in, vld_s1 && m_tvalid && !m_tready, !s_tready, "input taken while both stages are stalled")
	`SFPD_ASSERT_NEXT(a_emit_lands, advance && emit, m_tvalid, "emitted result lost")

endmodule

// ===== tb/sfpd_stream_checker.sv =====
// checker for the framed packet deframer: watches the sync register writes and both streams,
// predicts every result item and compares it with the block's output
// depends on sfpd_pkg
module sfpd_stream_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	input  logic [7:0]                   s_tdata,
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic [sfpd_pkg::TDATA_W-1:0] m_tdata,
	input  logic                         m_tuser,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [7:0]                   cfg_data,
	output int                           fail_count,
	output int                           due_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import sfpd_pkg::*;

	logic [7:0] sync_a;
	logic [7:0] sync_b;
	phase_t     ph;
	logic [7:0] prev_b;
	logic       prev_ok;
	logic [7:0] cur_id;
	logic [7:0] cur_len;
	logic [7:0] seen;
	logic [7:0] c0;
	logic [7:0] c1;
	logic [7:0] ck0;
	result_t    due_q[$];

	initial begin
		fail_count = 0;
		due_count = 0;
	end

	task automatic report_error(input string msg);
		$display("%0t ns: %s", $time, msg);
		fail_count = fail_count + 1;
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			report_error($sformatf("%s mismatch: got %0d want %0d", name, got, want));
	endtask

	task automatic deframe_byte(input logic [7:0] b);
		result_t r;
		r = '0;
		r.message_id = cur_id;
		r.frame_length = cur_len;
		case (ph)
			PH_ID: begin
				cur_id = b;
				c0 = b;
				c1 = b;
				ph = PH_LEN;
			end
			PH_LEN: begin
				cur_len = b;
				c0 = c0 + b;
				c1 = c1 + c0;
				seen = 8'd0;
				ph = (b == 8'd0) ? PH_CK0 : PH_DATA;
			end
			PH_DATA: begin
				r.item_kind = ITEM_PAYLOAD;
				r.byte_index = seen;
				r.payload_byte = b;
				due_q.insert(due_q.size(), r);
				c0 = c0 + b;
				c1 = c1 + c0;
				seen = seen + 8'd1;
				if (seen == cur_len)
					ph = PH_CK0;
			end
			PH_CK0: begin
				ck0 = b;
				ph = PH_CK1;
			end
			PH_CK1: begin
				r.item_kind = ITEM_FRAME_END;
				r.checksum_good = (c0 == ck0) && (c1 == b);
				due_q.insert(due_q.size(), r);
				ph = PH_HUNT;
				prev_ok = 1'b0;
				prev_b = 8'd0;
			end
			default: begin
				if (prev_ok && prev_b == sync_a && b == sync_b) begin
					ph = PH_ID;
					prev_ok = 1'b0;
					prev_b = 8'd0;
				end else begin
					ph = PH_HUNT;
					prev_b = b;
					prev_ok = 1'b1;
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			sync_a = SYNC_FIRST_RST;
			sync_b = SYNC_SECOND_RST;
			ph = PH_HUNT;
			prev_b = 8'd0;
			prev_ok = 1'b0;
			cur_id = 8'd0;
			cur_len = 8'd0;
			seen = 8'd0;
			c0 = 8'd0;
			c1 = 8'd0;
			ck0 = 8'd0;
			due_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (due_q.size() == 0) begin
					report_error($sformatf("result with nothing due: kind %0d data %h",
						m_tuser, m_tdata));
				end else begin
					want = due_q.pop_front();
					check_field("item_kind", {7'd0, m_tuser}, {7'd0, want.item_kind});
					check_field("message_id", m_tdata[7:0], want.message_id);
					check_field("byte_index", m_tdata[15:8], want.byte_index);
					check_field("payload_byte", m_tdata[23:16], want.payload_byte);
					check_field("frame_length", m_tdata[31:24], want.frame_length);
					check_field("checksum_good", {7'd0, m_tdata[32]},
						{7'd0, want.checksum_good});
				end
			end
			if (s_tvalid && s_tready)
				deframe_byte(s_tdata);
			if (cfg_we) begin
				if (cfg_index == CFG_SYNC_FIRST)
					sync_a = cfg_data;
				else
					sync_b = cfg_data;
			end
		end
		due_count = due_q.size();
	end

endmodule

// ===== tb/sync_framed_packet_deframer_core_tb.sv =====
// testbench top of the framed packet deframer: clock, reset, sync register writes,
// byte stream stimulus with random gaps and stalls, verdict
// depends on sfpd_pkg, sync_framed_packet_deframer_core and sfpd_stream_checker
module sync_framed_packet_deframer_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sfpd_pkg::*;

	localparam int LIMIT = 400000;
	localparam int FULL = 1000;
	localparam int BUDGET = 230;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [7:0]         s_tdata = 8'd0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;
	logic               m_tuser;
	logic               cfg_we = 1'b0;
	logic               cfg_index = CFG_SYNC_FIRST;
	logic [7:0]         cfg_data = 8'd0;

	int fail_count;
	int due_count;
	int cycle_count = 0;
	int gap_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;

	logic [7:0] tx_q[$];
	logic [7:0] pl_q[$];
	logic [7:0] cur_first = SYNC_FIRST_RST;
	logic [7:0] cur_second = SYNC_SECOND_RST;

	sync_framed_packet_deframer_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	sfpd_stream_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.due_count  (due_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: long hold-off when requested, random stalls otherwise
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left = hold_left - 1;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	initial begin
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL sync_framed_packet_deframer_core");
		$finish;
	end

	task automatic write_reg(input logic idx, input logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_stream();
		while (tx_q.size() != 0) begin
			if ($urandom_range(0, 99) < gap_pct) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end else begin
				s_tvalid <= 1'b1;
				s_tdata <= tx_q.pop_front();
				do @(posedge clk); while (!s_tready);
			end
		end
		s_tvalid <= 1'b0;
	endtask

	// wait until every result has come, then let the pipeline empty
	task automatic drain();
		do @(negedge clk); while (due_count != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic fill_payload(input int len);
		logic [7:0] b;
		pl_q.delete();
		repeat (len) begin
			b = 8'($urandom_range(0, 255));
			pl_q.insert(pl_q.size(), b);
		end
	endtask

	// sync pair, then the first keep bytes of id, length, payload and check bytes
	task automatic push_frame(input logic [7:0] id, input bit spoil, input int keep);
		logic [7:0] body[$];
		logic [7:0] s0;
		logic [7:0] s1;
		logic [7:0] len;
		len = 8'(pl_q.size());
		body.insert(body.size(), id);
		body.insert(body.size(), len);
		foreach (pl_q[i])
			body.insert(body.size(), pl_q[i]);
		s0 = 8'd0;
		s1 = 8'd0;
		foreach (body[i]) begin
			s0 = s0 + body[i];
			s1 = s1 + s0;
		end
		if (spoil) begin
			case ($urandom_range(0, 2))
				0: s0 = s0 ^ (8'd1 << $urandom_range(0, 7));
				1: s1 = s1 ^ (8'd1 << $urandom_range(0, 7));
				default: begin
					s0 = s0 ^ (8'd1 << $urandom_range(0, 7));
					s1 = s1 ^ (8'd1 << $urandom_range(0, 7));
				end
			endcase
		end
		body.insert(body.size(), s0);
		body.insert(body.size(), s1);
		tx_q.insert(tx_q.size(), cur_first);
		tx_q.insert(tx_q.size(), cur_second);
		for (int i = 0; i < body.size() && i < keep; i++)
			tx_q.insert(tx_q.size(), body[i]);
	endtask

	task automatic build_random(input int budget);
		int len;
		logic [7:0] id;
		logic [7:0] b;
		while (tx_q.size() < budget) begin
			len = ($urandom_range(0, 39) == 0) ? 255 : $urandom_range(0, 12);
			id = 8'($urandom_range(0, 255));
			fill_payload(len);
			case ($urandom_range(0, 9))
				7: begin
					repeat ($urandom_range(1, 6)) begin
						b = 8'($urandom_range(0, 255));
						tx_q.insert(tx_q.size(), b);
					end
				end
				8: push_frame(id, 1'b0, $urandom_range(0, len + 3));
				9: begin
					tx_q.insert(tx_q.size(), cur_first);
					push_frame(id, 1'b0, FULL);
				end
				default: push_frame(id, $urandom_range(0, 3) == 0, FULL);
			endcase
		end
	endtask

	initial begin
		int mode;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// noise extremes, overlapping sync with zero length, sync inside payload, bad check
		tx_q.insert(tx_q.size(), 8'h00);
		tx_q.insert(tx_q.size(), 8'hff);
		tx_q.insert(tx_q.size(), cur_first);
		pl_q.delete();
		push_frame(8'h00, 1'b0, FULL);
		pl_q.delete();
		pl_q.insert(pl_q.size(), cur_first);
		pl_q.insert(pl_q.size(), cur_second);
		push_frame(8'hff, 1'b0, FULL);
		pl_q.delete();
		pl_q.insert(pl_q.size(), 8'hff);
		push_frame(8'hff, 1'b1, FULL);
		send_stream();
		drain();

		for (int p = 0; p < 6; p++) begin
			mode = p % 4;
			gap_pct = (mode == 1) ? 88 : (mode == 3) ? 25 : 0;
			stall_pct = (mode == 2) ? 88 : (mode == 3) ? 25 : 0;
			case (p)
				0: begin cur_first = SYNC_FIRST_RST; cur_second = SYNC_SECOND_RST; end
				1: begin cur_first = 8'h00; cur_second = 8'h00; end
				2: begin cur_first = 8'hff; cur_second = 8'hff; end
				3: begin cur_first = 8'h00; cur_second = 8'hff; end
				4: begin
					cur_first = 8'($urandom_range(0, 255));
					cur_second = 8'($urandom_range(0, 255));
				end
				default: begin cur_first = 8'hff; cur_second = 8'h00; end
			endcase
			write_reg(CFG_SYNC_FIRST, cur_first);
			write_reg(CFG_SYNC_SECOND, cur_second);
			if (p == 0) begin
				fill_payload(255);
				push_frame(8'($urandom_range(0, 255)), 1'b0, FULL);
			end
			build_random(BUDGET);
			if (p == 0)
				hold_left = 300;
			send_stream();
			drain();
		end

		@(negedge clk);
		if (fail_count == 0)
			$display("PASS sync_framed_packet_deframer_core");
		else
			$display("FAIL sync_framed_packet_deframer_core");
		$finish;
	end

endmodule
